// File: sv/tkpt_pkg.sv
// ----------------------------------------------------------------------------
// tkpt_pkg
// Shared types and constants for the top-k peak tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tkpt_pkg;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned IndexW   = 3;
  localparam int unsigned MaxEmit  = 8;

  localparam logic [ValueW-1:0] VALUE_CEIL = 16'hFFFF;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAIT,
    ST_SRD,
    ST_SUPD,
    ST_DRD,
    ST_DOUT
  } state_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [TimeW-1:0]  rel_time;
  } entry_t;

  typedef struct packed {
    logic re;
    logic we;
    logic clr;
  } mem_ctl_t;

  typedef struct packed {
    logic              load;
    logic              last;
    logic [IndexW-1:0] index;
  } dump_ctl_t;

endpackage

`default_nettype wire

// File: sv/tkpt_mem.sv
// ----------------------------------------------------------------------------
// tkpt_mem
// Entry store: one-port synchronous RAM, registered read, with
// per-entry valid bits so unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tkpt_mem #(
  parameter int unsigned Entries = 8,
  parameter int unsigned AddrW   = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tkpt_pkg::mem_ctl_t ctl_i,
  input  wire logic [AddrW-1:0]  addr_i,
  input  wire tkpt_pkg::entry_t  wr_data_i,
  output tkpt_pkg::entry_t       rd_data_o
);

  tkpt_pkg::entry_t mem [Entries];
  tkpt_pkg::entry_t rd_q;
  logic             rd_vld_q;
  logic [Entries-1:0] vld_q;

  // array and read data: no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wr_data_i;
    end
    if (ctl_i.re) begin
      rd_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.re) begin
        rd_vld_q <= vld_q[addr_i];
      end
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.we) begin
        vld_q[addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: sv/tkpt_ctrl.sv
// ----------------------------------------------------------------------------
// tkpt_ctrl
// Sequencer: minimum scan and read-modify-write for samples, entry
// read-out and clear for dumps.
// ----------------------------------------------------------------------------
`default_nettype none

module tkpt_ctrl #(
  parameter int unsigned Entries = 8,
  parameter int unsigned AddrW   = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          kind_i,
  input  wire logic [tkpt_pkg::ValueW-1:0]   sample_value_i,
  input  wire logic [tkpt_pkg::TimeW-1:0]    now_seconds_i,
  output logic                               in_stall_o,
  input  wire logic                          out_free_i,
  input  wire tkpt_pkg::entry_t              rd_data_i,
  output tkpt_pkg::mem_ctl_t                 mem_ctl_o,
  output logic [AddrW-1:0]                   mem_addr_o,
  output tkpt_pkg::entry_t                   wr_data_o,
  output tkpt_pkg::dump_ctl_t                dump_o
);

  localparam int unsigned NumEmit = (Entries < tkpt_pkg::MaxEmit) ? Entries
                                                                  : tkpt_pkg::MaxEmit;
  localparam logic [AddrW-1:0] ScanLast = AddrW'(Entries - 1);
  localparam logic [AddrW-1:0] DumpLast = AddrW'(NumEmit - 1);

  tkpt_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q;
  logic             cmpv_q, cmpv_d;
  logic [tkpt_pkg::ValueW-1:0] best_q, best_d;
  logic [tkpt_pkg::IndexW-1:0] slot_q, slot_d;
  logic [tkpt_pkg::TimeW-1:0]  ps_q, ps_d;
  logic [tkpt_pkg::ValueW-1:0] val_q;
  logic [tkpt_pkg::TimeW-1:0]  rel_q, rel_d;

  logic accept;
  logic slot_ok;
  logic take_min;
  logic dump_last;

  assign accept    = in_valid_i && (state_q == tkpt_pkg::ST_IDLE);
  assign slot_ok   = 32'(slot_q) < Entries;
  assign take_min  = cmpv_q && (rd_data_i.value < best_q);
  assign dump_last = cnt_q == DumpLast;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tkpt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (kind_i == tkpt_pkg::KIND_DUMP) ? tkpt_pkg::ST_DRD : tkpt_pkg::ST_SCAN;
        end
      end
      tkpt_pkg::ST_SCAN: begin
        if (cnt_q == ScanLast) begin
          state_d = tkpt_pkg::ST_SWAIT;
        end
      end
      tkpt_pkg::ST_SWAIT: state_d = tkpt_pkg::ST_SRD;
      tkpt_pkg::ST_SRD:   state_d = tkpt_pkg::ST_SUPD;
      tkpt_pkg::ST_SUPD:  state_d = tkpt_pkg::ST_IDLE;
      tkpt_pkg::ST_DRD:   state_d = tkpt_pkg::ST_DOUT;
      tkpt_pkg::ST_DOUT: begin
        if (out_free_i) begin
          state_d = dump_last ? tkpt_pkg::ST_IDLE : tkpt_pkg::ST_DRD;
        end
      end
      default: state_d = tkpt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o   = 1'b1;
    mem_ctl_o    = '0;
    mem_addr_o   = cnt_q;
    wr_data_o    = '{value: val_q, rel_time: rel_q};
    dump_o       = '0;
    dump_o.index = tkpt_pkg::IndexW'(cnt_q);
    unique case (state_q)
      tkpt_pkg::ST_IDLE:  in_stall_o = 1'b0;
      tkpt_pkg::ST_SCAN:  mem_ctl_o.re = 1'b1;
      tkpt_pkg::ST_SWAIT: ;
      tkpt_pkg::ST_SRD: begin
        mem_ctl_o.re = 1'b1;
        mem_addr_o   = AddrW'(slot_q);
      end
      tkpt_pkg::ST_SUPD: begin
        mem_addr_o   = AddrW'(slot_q);
        mem_ctl_o.we = slot_ok && (rd_data_i.value < val_q);
      end
      tkpt_pkg::ST_DRD:   mem_ctl_o.re = 1'b1;
      tkpt_pkg::ST_DOUT: begin
        dump_o.load   = out_free_i;
        dump_o.last   = dump_last;
        mem_ctl_o.clr = out_free_i && dump_last;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_d  = cnt_q;
    cmpv_d = state_q == tkpt_pkg::ST_SCAN;
    best_d = best_q;
    slot_d = slot_q;
    ps_d   = ps_q;
    rel_d  = rel_q;
    if (accept) begin
      cnt_d = '0;
      if (kind_i == tkpt_pkg::KIND_SAMPLE) begin
        best_d = tkpt_pkg::VALUE_CEIL;
        if (ps_q == '0) begin
          ps_d  = now_seconds_i;
          rel_d = '0;
        end else begin
          rel_d = now_seconds_i - ps_q;
        end
      end
    end
    if (take_min) begin
      best_d = rd_data_i.value;
      slot_d = tkpt_pkg::IndexW'(idx_q);
    end
    if (state_q == tkpt_pkg::ST_SCAN && cnt_q != ScanLast) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (state_q == tkpt_pkg::ST_DOUT && out_free_i) begin
      if (dump_last) begin
        ps_d   = '0;
        slot_d = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tkpt_pkg::ST_IDLE;
      cnt_q   <= '0;
      cmpv_q  <= 1'b0;
      best_q  <= tkpt_pkg::VALUE_CEIL;
      slot_q  <= '0;
      ps_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cmpv_q  <= cmpv_d;
      best_q  <= best_d;
      slot_q  <= slot_d;
      ps_q    <= ps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= cnt_q;
    rel_q <= rel_d;
    if (accept) begin
      val_q <= sample_value_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.re && mem_ctl_o.we))
    else $error("read and write issued in the same cycle");

  a_cmp_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmpv_q |-> (idx_q == $past(cnt_q)))
    else $error("compare index does not match issued read");

  a_clr_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.clr |-> (dump_o.load && dump_o.last))
    else $error("store cleared outside the final dump beat");

  a_idle_after_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump_o.load && dump_o.last) |=> (state_q == tkpt_pkg::ST_IDLE && ps_q == '0))
    else $error("not idle and cleared after final dump beat");
`endif

endmodule

`default_nettype wire

// File: sv/top_k_peak_tracker_core.sv
// ----------------------------------------------------------------------------
// top_k_peak_tracker_core
// Keeps the Entries largest samples of a collection period with their
// times relative to the period start; a dump beat-streams them and clears.
// ----------------------------------------------------------------------------
// Sample: the input stalls from acceptance until the one-entry-per-cycle
//   minimum scan over the single RAM read port and the read-modify-write
//   of the chosen entry are done.
// Dump: each emitted beat is a RAM read, then an output load, held back
//   while the output is stalled; input stalls until the final beat is loaded.
// Reset clears control state and all entry valid bits; entries read as zero.
`default_nettype none

module top_k_peak_tracker_core #(
  parameter int unsigned ENTRIES = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [tkpt_pkg::ValueW-1:0]   sample_value_i,
  input  wire logic [tkpt_pkg::TimeW-1:0]    now_seconds_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tkpt_pkg::IndexW-1:0]        entry_index_o,
  output logic [tkpt_pkg::ValueW-1:0]        entry_value_o,
  output logic [tkpt_pkg::TimeW-1:0]         entry_time_o,
  output logic                               last_o
);

  // address width; a single-entry store still gets one address bit
  localparam int unsigned AddrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  tkpt_pkg::mem_ctl_t  mem_ctl;
  tkpt_pkg::dump_ctl_t dump;
  tkpt_pkg::entry_t    rd_data;
  tkpt_pkg::entry_t    wr_data;
  logic [AddrW-1:0]    mem_addr;

  logic out_vld_q, out_vld_d;
  logic out_free;

  tkpt_pkg::entry_t            out_entry_q;
  logic [tkpt_pkg::IndexW-1:0] out_index_q;
  logic                        out_last_q;

  // output register may be refilled in the cycle its beat is taken
  assign out_free = !out_vld_q || !out_stall_i;

  tkpt_ctrl #(
    .Entries (ENTRIES),
    .AddrW   (AddrW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .kind_i         (kind_i),
    .sample_value_i (sample_value_i),
    .now_seconds_i  (now_seconds_i),
    .in_stall_o     (in_stall_o),
    .out_free_i     (out_free),
    .rd_data_i      (rd_data),
    .mem_ctl_o      (mem_ctl),
    .mem_addr_o     (mem_addr),
    .wr_data_o      (wr_data),
    .dump_o         (dump)
  );

  tkpt_mem #(
    .Entries (ENTRIES),
    .AddrW   (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .addr_i    (mem_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // output beat register
  always_comb begin
    out_vld_d = out_vld_q;
    if (dump.load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dump.load) begin
      out_entry_q <= rd_data;
      out_index_q <= dump.index;
      out_last_q  <= dump.last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign entry_index_o = out_index_q;
  assign entry_value_o = out_entry_q.value;
  assign entry_time_o  = out_entry_q.rel_time;
  assign last_o        = out_last_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump.load |-> out_free)
    else $error("output beat overwritten while stalled");

  a_busy_while_dumping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump.load && !dump.last) |-> in_stall_o)
    else $error("input open in the middle of a dump");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump.load && dump.last) |->
      (32'(dump.index) == ((ENTRIES < tkpt_pkg::MaxEmit) ? ENTRIES : tkpt_pkg::MaxEmit) - 1))
    else $error("final dump beat carries wrong index");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top_k_peak_tracker_core.sv
// ----------------------------------------------------------------------------
// tb_top_k_peak_tracker_core
// Self-checking bench for the top-k peak tracker core: sample and dump items
// go in, an in-bench tracker of the same store predicts every dump beat, and
// each beat is checked field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top_k_peak_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES     = 8;
  localparam int unsigned EmitCount   = (ENTRIES < tkpt_pkg::MaxEmit) ? ENTRIES
                                                                      : tkpt_pkg::MaxEmit;
  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned RandomItems = 200;
  // a sample gives no beat, so allow enough for one to run to its end and more
  localparam int unsigned SettleCycles = 4 * ENTRIES + 8;
  localparam int unsigned CycleLimit   = 400000;

  typedef struct packed {
    logic [tkpt_pkg::IndexW-1:0] index;
    logic [tkpt_pkg::ValueW-1:0] value;
    logic [tkpt_pkg::TimeW-1:0]  rel_time;
    logic                        last;
  } peak_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        kind_i;
  logic [tkpt_pkg::ValueW-1:0] sample_value_i;
  logic [tkpt_pkg::TimeW-1:0]  now_seconds_i;

  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [tkpt_pkg::IndexW-1:0] entry_index_o;
  logic [tkpt_pkg::ValueW-1:0] entry_value_o;
  logic [tkpt_pkg::TimeW-1:0]  entry_time_o;
  logic                        last_o;

  // tracker copy of the peak store
  logic [tkpt_pkg::ValueW-1:0] peak_value_q [ENTRIES];
  logic [tkpt_pkg::TimeW-1:0]  peak_time_q  [ENTRIES];
  logic [tkpt_pkg::TimeW-1:0]  period_start_q;
  logic [tkpt_pkg::IndexW-1:0] lowest_slot_q;

  peak_beat_t  dump_beats_due[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // pacing controls shared between the stimulus and the receiver
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_hold_len = 0;

  top_k_peak_tracker_core #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .sample_value_i (sample_value_i),
    .now_seconds_i  (now_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .entry_index_o  (entry_index_o),
    .entry_value_o  (entry_value_o),
    .entry_time_o   (entry_time_o),
    .last_o         (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Tracker model
  // ---------------------------------------------------------------------------
  function automatic void clear_peaks();
    for (int i = 0; i < ENTRIES; i++) begin
      peak_value_q[i] = '0;
      peak_time_q[i]  = '0;
    end
    period_start_q = '0;
    lowest_slot_q  = '0;
  endfunction

  // Start of zero means unset; the scan only moves on a strictly lower value,
  // so an all-ceiling store leaves the slot where it was.
  function automatic void track_sample(logic [tkpt_pkg::ValueW-1:0] value,
                                       logic [tkpt_pkg::TimeW-1:0] now);
    logic [tkpt_pkg::ValueW-1:0] lowest;
    lowest = tkpt_pkg::VALUE_CEIL;
    if (period_start_q == '0) period_start_q = now;
    for (int i = 0; i < ENTRIES; i++) begin
      if (peak_value_q[i] < lowest) begin
        lowest        = peak_value_q[i];
        lowest_slot_q = tkpt_pkg::IndexW'(i);
      end
    end
    if (int'(lowest_slot_q) < ENTRIES && peak_value_q[lowest_slot_q] < value) begin
      peak_value_q[lowest_slot_q] = value;
      peak_time_q[lowest_slot_q]  = now - period_start_q;
    end
  endfunction

  function automatic void dump_peaks();
    peak_beat_t b;
    for (int k = 0; k < EmitCount; k++) begin
      b.index    = tkpt_pkg::IndexW'(k);
      b.value    = peak_value_q[k];
      b.rel_time = peak_time_q[k];
      b.last     = (k + 1 == EmitCount);
      dump_beats_due.push_back(b);
    end
    clear_peaks();
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // mostly nothing or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Called at a falling edge; returns at a falling edge. Valid stays high
  // when no gap follows, so back-to-back beats need no re-raise.
  task automatic send_beat(logic kind, logic [tkpt_pkg::ValueW-1:0] value,
                           logic [tkpt_pkg::TimeW-1:0] now);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    sample_value_i <= value;
    now_seconds_i  <= now;
    do @(posedge clk_i); while (in_stall_o);
    if (kind == tkpt_pkg::KIND_SAMPLE) track_sample(value, now);
    else dump_peaks();
    @(negedge clk_i);
    gap = tx_quiet ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // sender pauses until every beat due has arrived, then lets a sample finish
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (dump_beats_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing: random stalls, quiet stretches and a requested hold-off
  // ---------------------------------------------------------------------------
  initial begin : rx_pacing
    int unsigned n;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        n = rx_hold_len;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
        rx_hold_req = 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        n = 1 + idle_len();
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Beat checker: every accepted output beat against the oldest one due
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : beat_check
    peak_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dump_beats_due.size() == 0) begin
        report_mismatch("beat with none due, index", 32'(entry_index_o), 32'(0));
      end else begin
        want = dump_beats_due.pop_front();
        if (entry_index_o !== want.index)
          report_mismatch("entry_index", 32'(entry_index_o), 32'(want.index));
        if (entry_value_o !== want.value)
          report_mismatch("entry_value", 32'(entry_value_o), 32'(want.value));
        if (entry_time_o !== want.rel_time)
          report_mismatch("entry_time", entry_time_o, want.rel_time);
        if (last_o !== want.last)
          report_mismatch("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  // generous bound on the slowest correct run
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // dump straight after reset: all entries zero, last on the final one
  task automatic test_empty_dump();
    send_beat(tkpt_pkg::KIND_DUMP, 16'hA5A5, 32'h1234_5678);
    wait_quiet();
  endtask

  // start left unset by a zero time, lowest index wins ties, equal sample
  // is not taken, far end of the time range
  task automatic test_ranking_and_ties();
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h0001, 32'h0000_0000);
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h0005, 32'd100);
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h0000, 32'd150);
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h0001, 32'd200);
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(tkpt_pkg::KIND_DUMP,   16'h0000, 32'h0000_0000);
    wait_quiet();
  endtask

  // store full of ceiling values: slot stays put, nothing replaced
  task automatic test_ceiling_fill();
    for (int i = 0; i < ENTRIES; i++)
      send_beat(tkpt_pkg::KIND_SAMPLE, tkpt_pkg::VALUE_CEIL, 32'(7 + i));
    send_beat(tkpt_pkg::KIND_SAMPLE, tkpt_pkg::VALUE_CEIL, 32'd50);
    send_beat(tkpt_pkg::KIND_DUMP, tkpt_pkg::VALUE_CEIL, 32'hFFFF_FFFF);
    wait_quiet();
  endtask

  // relative time wraps modulo 2^32; sample field ignored on a dump
  task automatic test_time_wrap();
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h1234, 32'hFFFF_FFF0);
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h2000, 32'h0000_0010);
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h3000, 32'h0000_0000);
    send_beat(tkpt_pkg::KIND_DUMP,   16'hFFFF, 32'hDEAD_BEEF);
    wait_quiet();
  endtask

  // receiver holds off while the sender keeps offering beats back to back,
  // so the dump backs up and the input stalls
  task automatic test_output_hold_off();
    tx_quiet    = 1'b1;
    rx_hold_len = 300;
    rx_hold_req = 1'b1;
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h0100, 32'd1000);
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h0200, 32'd1003);
    send_beat(tkpt_pkg::KIND_DUMP,   16'h0000, 32'd1004);
    send_beat(tkpt_pkg::KIND_SAMPLE, 16'h0300, 32'd2000);
    send_beat(tkpt_pkg::KIND_DUMP,   16'h0000, 32'd2001);
    send_beat(tkpt_pkg::KIND_DUMP,   16'h0000, 32'd2002);
    tx_quiet = 1'b0;
    wait_quiet();
  endtask

  // collection periods: a run of samples with a ticking clock, then a dump
  task automatic test_random_periods();
    int unsigned sent;
    int unsigned n;
    int unsigned sel;
    logic [tkpt_pkg::TimeW-1:0]  clock_s;
    logic [tkpt_pkg::ValueW-1:0] value;
    sent = 0;
    while (sent < RandomItems) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 9);
      if (sel == 0)      clock_s = '0;
      else if (sel == 1) clock_s = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else               clock_s = $urandom();
      n = $urandom_range(0, 16);
      repeat (n) begin
        sel = $urandom_range(0, 9);
        if (sel < 5)      value = tkpt_pkg::ValueW'($urandom());
        else if (sel < 7) value = tkpt_pkg::ValueW'($urandom_range(0, 4));
        else if (sel < 9) value = tkpt_pkg::ValueW'(32'hFFF0 + $urandom_range(0, 15));
        else              value = tkpt_pkg::VALUE_CEIL;
        send_beat(tkpt_pkg::KIND_SAMPLE, value, clock_s);
        sent++;
        sel = $urandom_range(0, 11);
        if (sel == 0)      clock_s = $urandom();
        else if (sel == 1) clock_s = '0;
        else               clock_s = clock_s + $urandom_range(0, 3);
      end
      send_beat(tkpt_pkg::KIND_DUMP, tkpt_pkg::ValueW'($urandom()), $urandom());
      sent++;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_quiet();
  endtask

  initial begin : run_tests
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    kind_i         <= tkpt_pkg::KIND_SAMPLE;
    sample_value_i <= '0;
    now_seconds_i  <= '0;
    clear_peaks();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_dump();
    test_ranking_and_ties();
    test_ceiling_fill();
    test_time_wrap();
    test_output_hold_off();
    test_random_periods();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
